### src/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants of the go-back-n sender
// event, phase and result codes, configuration view, and the command and
// status bundles between the controller and the datapath
// ----------------------------------------------------------------------------
package gbn_pkg;

  // widest window the sender supports and the most results one event may cause
  localparam int unsigned MaxWindow = 32;
  localparam int unsigned ResultCap = 32;
  localparam int unsigned WinCap    = (MaxWindow < ResultCap) ? MaxWindow : ResultCap;
  localparam int unsigned CntW      = $clog2(ResultCap + 1);

  localparam logic [5:0]      WinCapW = 6'(WinCap);
  localparam logic [CntW-1:0] CntCap  = CntW'(ResultCap);

  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    FuncStart   = 2'd0,
    FuncAck     = 2'd1,
    FuncTimeout = 2'd2,
    FuncBad     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhData = 2'd1,
    PhEnd  = 2'd2,
    PhDone = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KindData   = 3'd0,
    KindEnd    = 3'd1,
    KindDone   = 3'd2,
    KindAbort  = 3'd3,
    KindGaveUp = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CfgExpSession  = 3'd0,
    CfgChunkTotal  = 3'd1,
    CfgFirstChunk  = 3'd2,
    CfgWindowLimit = 3'd3,
    CfgEndTries    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EmitNone   = 2'd0,
    EmitResend = 2'd1,
    EmitFill   = 2'd2,
    EmitSingle = 2'd3
  } emit_e;

  typedef enum logic [1:0] {
    AttKeep = 2'd0,
    AttOne  = 2'd1,
    AttInc  = 2'd2
  } att_e;

  // register contents as the datapath sees them, window already clamped
  typedef struct packed {
    logic [31:0] expected_session;
    logic [31:0] chunk_total;
    logic [31:0] first_chunk;
    logic [7:0]  end_tries;
    logic [5:0]  window;
  } cfg_t;

  typedef struct packed {
    logic   load_in;
    logic   start_xfer;
    logic   ack_base;
    logic   fix_next;
    logic   load_lim;
    logic   load_cursor;
    emit_e  emit;
    logic   set_phase;
    phase_e phase;
    att_e   att;
    logic   pend_load;
    kind_e  pend_kind;
  } cmd_t;

  typedef struct packed {
    func_e  func;
    phase_e phase;
    logic   sess_match;
    logic   ack_eq_total;
    logic   att_lt_tries;
    logic   tries_zero;
    logic   base_ge_total;
    logic   cnt_room;
    logic   resend_more;
    logic   fill_more;
    logic   out_free;
  } sts_t;

endpackage

### src/gbn_cfg.sv
// ----------------------------------------------------------------------------
// gbn_cfg: configuration registers
// holds the five registers and presents the clamped window to the datapath
// ----------------------------------------------------------------------------
module gbn_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output gbn_pkg::cfg_t cfg_o
);
  import gbn_pkg::*;

  logic [31:0] sess_q, total_q, first_q;
  logic [5:0]  wlim_q;
  logic [7:0]  tries_q;
  logic [5:0]  win;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q  <= '0;
      total_q <= '0;
      first_q <= '0;
      wlim_q  <= 6'd8;
      tries_q <= 8'd5;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgExpSession:  sess_q  <= cfg_data_i;
        CfgChunkTotal:  total_q <= cfg_data_i;
        CfgFirstChunk:  first_q <= cfg_data_i;
        CfgWindowLimit: wlim_q  <= cfg_data_i[5:0];
        CfgEndTries:    tries_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the cap is cut to the cap
  always_comb begin
    if (wlim_q == 6'd0) begin
      win = 6'd1;
    end else if (wlim_q > WinCapW) begin
      win = WinCapW;
    end else begin
      win = wlim_q;
    end
  end

  assign cfg_o.expected_session = sess_q;
  assign cfg_o.chunk_total      = total_q;
  assign cfg_o.first_chunk      = first_q;
  assign cfg_o.end_tries        = tries_q;
  assign cfg_o.window           = win;

endmodule

### src/gbn_dp.sv
// ----------------------------------------------------------------------------
// gbn_dp: sender datapath
// window pointers, end attempt count, result counter and output register
// ----------------------------------------------------------------------------
module gbn_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gbn_pkg::cfg_t cfg_i,
  input  gbn_pkg::cmd_t cmd_i,
  output gbn_pkg::sts_t sts_o,
  input  logic [63:0]   in_data_i,
  input  logic [1:0]    in_user_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_data_o,
  output logic [2:0]    out_user_o,
  output logic          out_last_o
);
  import gbn_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] base_q, base_d;
  logic [31:0] next_q, next_d;
  logic [7:0]  att_q, att_d;
  logic        m_valid_q, m_valid_d;

  func_e       func_q, func_d;
  logic [31:0] sess_q, sess_d;
  logic [31:0] ack_q, ack_d;
  logic [32:0] lim_q, lim_d;
  logic [31:0] cur_q, cur_d;
  cnt_t        cnt_q, cnt_d;
  kind_e       pend_q, pend_d;
  kind_e       m_kind_q, m_kind_d;
  logic [31:0] m_num_q, m_num_d;
  logic        m_last_q, m_last_d;

  logic        ack_gt_base, cnt_room, room_nx;
  logic        next_lt_lim, next_lt_total, base_ge_total;
  logic        resend_more, fill_more, resend_more_nx, fill_more_nx;
  logic [32:0] next_inc, cur_inc, total_x;
  cnt_t        cnt_inc;

  assign total_x       = {1'b0, cfg_i.chunk_total};
  assign next_inc      = {1'b0, next_q} + 33'd1;
  assign cur_inc       = {1'b0, cur_q} + 33'd1;
  assign cnt_inc       = cnt_q + CntW'(1);

  assign ack_gt_base   = ack_q > base_q;
  assign base_ge_total = base_q >= cfg_i.chunk_total;
  assign cnt_room      = cnt_q < CntCap;
  assign room_nx       = cnt_inc < CntCap;
  assign next_lt_lim   = {1'b0, next_q} < lim_q;
  assign next_lt_total = next_q < cfg_i.chunk_total;
  assign resend_more   = cnt_room && (cur_q < next_q);
  assign fill_more     = cnt_room && next_lt_lim && next_lt_total;

  // lookahead: does another result follow the one going out now
  assign fill_more_nx   = room_nx && (next_inc < lim_q) && (next_inc < total_x);
  assign resend_more_nx = room_nx && ((cur_inc < {1'b0, next_q}) || base_ge_total ||
                                      (next_lt_lim && next_lt_total));

  always_comb begin
    phase_d   = phase_q;
    base_d    = base_q;
    next_d    = next_q;
    att_d     = att_q;
    func_d    = func_q;
    sess_d    = sess_q;
    ack_d     = ack_q;
    lim_d     = lim_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    m_valid_d = m_valid_q && !out_ready_i;
    m_kind_d  = m_kind_q;
    m_num_d   = m_num_q;
    m_last_d  = m_last_q;

    if (cmd_i.load_in) begin
      func_d = func_e'(in_user_i);
      sess_d = in_data_i[31:0];
      ack_d  = in_data_i[63:32];
      cnt_d  = '0;
    end
    if (cmd_i.start_xfer) begin
      base_d = cfg_i.first_chunk;
      next_d = cfg_i.first_chunk;
    end
    if (cmd_i.ack_base && ack_gt_base) begin
      base_d = ack_q;
    end
    if (cmd_i.fix_next && (next_q < base_q)) begin
      next_d = base_q;
    end
    // window edge kept 33 bits wide so it never wraps
    if (cmd_i.load_lim) begin
      lim_d = {1'b0, base_q} + {27'd0, cfg_i.window};
    end
    if (cmd_i.load_cursor) begin
      cur_d = base_q;
    end
    if (cmd_i.set_phase) begin
      phase_d = cmd_i.phase;
    end
    case (cmd_i.att)
      AttOne:  att_d = 8'd1;
      AttInc:  att_d = att_q + 8'd1;
      default: ;
    endcase
    if (cmd_i.pend_load) begin
      pend_d = cmd_i.pend_kind;
    end

    unique case (cmd_i.emit)
      EmitNone: ;
      EmitResend: begin
        m_valid_d = 1'b1;
        m_kind_d  = KindData;
        m_num_d   = cur_q;
        m_last_d  = !resend_more_nx;
        cur_d     = cur_q + 32'd1;
        cnt_d     = cnt_inc;
      end
      EmitFill: begin
        m_valid_d = 1'b1;
        m_kind_d  = KindData;
        m_num_d   = next_q;
        m_last_d  = !fill_more_nx;
        next_d    = next_q + 32'd1;
        cnt_d     = cnt_inc;
      end
      EmitSingle: begin
        m_valid_d = 1'b1;
        m_kind_d  = pend_q;
        m_num_d   = (pend_q == KindEnd) ? cfg_i.chunk_total : 32'd0;
        m_last_d  = 1'b1;
        cnt_d     = cnt_inc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      base_q    <= '0;
      next_q    <= '0;
      att_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      base_q    <= base_d;
      next_q    <= next_d;
      att_q     <= att_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    sess_q   <= sess_d;
    ack_q    <= ack_d;
    lim_q    <= lim_d;
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    pend_q   <= pend_d;
    m_kind_q <= m_kind_d;
    m_num_q  <= m_num_d;
    m_last_q <= m_last_d;
  end

  assign sts_o.func          = func_q;
  assign sts_o.phase         = phase_q;
  assign sts_o.sess_match    = sess_q == cfg_i.expected_session;
  assign sts_o.ack_eq_total  = ack_q == cfg_i.chunk_total;
  assign sts_o.att_lt_tries  = att_q < cfg_i.end_tries;
  assign sts_o.tries_zero    = cfg_i.end_tries == 8'd0;
  assign sts_o.base_ge_total = base_ge_total;
  assign sts_o.cnt_room      = cnt_room;
  assign sts_o.resend_more   = resend_more;
  assign sts_o.fill_more     = fill_more;
  assign sts_o.out_free      = !m_valid_q || out_ready_i;

  assign out_valid_o = m_valid_q;
  assign out_data_o  = m_num_q;
  assign out_user_o  = m_kind_q;
  assign out_last_o  = m_last_q;

endmodule

### src/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl: sender controller
// decodes each event against the phase and steps the datapath through
// resend, window fill and single status results
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gbn_pkg::sts_t sts_i,
  output gbn_pkg::cmd_t cmd_o
);
  import gbn_pkg::*;

  typedef enum logic [6:0] {
    StWait   = 7'b0000001,
    StDecode = 7'b0000010,
    StAckFix = 7'b0000100,
    StAdv    = 7'b0001000,
    StResend = 7'b0010000,
    StFill   = 7'b0100000,
    StSingle = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      StWait: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = StDecode;
        end
      end

      StDecode: begin
        unique case (sts_i.phase)
          PhIdle: begin
            if (sts_i.func == FuncTimeout) begin
              state_d = StWait;
            end else if (sts_i.func == FuncStart && sts_i.sess_match) begin
              cmd_o.start_xfer = 1'b1;
              cmd_o.set_phase  = 1'b1;
              cmd_o.phase      = PhData;
              state_d          = StAdv;
            end else begin
              cmd_o.set_phase = 1'b1;
              cmd_o.phase     = PhDone;
              cmd_o.pend_load = 1'b1;
              cmd_o.pend_kind = KindAbort;
              state_d         = StSingle;
            end
          end
          PhData: begin
            if (sts_i.func == FuncAck) begin
              cmd_o.ack_base = 1'b1;
              state_d        = StAckFix;
            end else if (sts_i.func == FuncTimeout) begin
              cmd_o.load_cursor = 1'b1;
              cmd_o.load_lim    = 1'b1;
              state_d           = StResend;
            end else begin
              cmd_o.set_phase = 1'b1;
              cmd_o.phase     = PhDone;
              cmd_o.pend_load = 1'b1;
              cmd_o.pend_kind = KindAbort;
              state_d         = StSingle;
            end
          end
          PhEnd: begin
            cmd_o.pend_load = 1'b1;
            state_d         = StSingle;
            if (sts_i.func == FuncAck && sts_i.ack_eq_total) begin
              cmd_o.pend_kind = KindDone;
              cmd_o.set_phase = 1'b1;
              cmd_o.phase     = PhDone;
            end else if (sts_i.att_lt_tries) begin
              cmd_o.pend_kind = KindEnd;
              cmd_o.att       = AttInc;
            end else begin
              cmd_o.pend_kind = KindGaveUp;
              cmd_o.set_phase = 1'b1;
              cmd_o.phase     = PhDone;
            end
          end
          PhDone: begin
            state_d = StWait;
          end
        endcase
      end

      StAckFix: begin
        cmd_o.fix_next = 1'b1;
        state_d        = StAdv;
      end

      // every chunk acknowledged: move to the end phase (or to done when end tries is zero), else refill
      StAdv: begin
        if (sts_i.base_ge_total) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.set_phase = 1'b1;
          if (sts_i.tries_zero) begin
            cmd_o.pend_kind = KindGaveUp;
            cmd_o.phase     = PhDone;
          end else begin
            cmd_o.pend_kind = KindEnd;
            cmd_o.phase     = PhEnd;
            cmd_o.att       = AttOne;
          end
          state_d = sts_i.cnt_room ? StSingle : StWait;
        end else begin
          cmd_o.load_lim = 1'b1;
          state_d        = StFill;
        end
      end

      StResend: begin
        if (sts_i.resend_more) begin
          if (sts_i.out_free) begin
            cmd_o.emit = EmitResend;
          end
        end else begin
          state_d = StAdv;
        end
      end

      StFill: begin
        if (sts_i.fill_more) begin
          if (sts_i.out_free) begin
            cmd_o.emit = EmitFill;
          end
        end else begin
          state_d = StWait;
        end
      end

      StSingle: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EmitSingle;
          state_d    = StWait;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StWait;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/go_back_n_sender.sv
// ----------------------------------------------------------------------------
// go_back_n_sender: go-back-n sliding-window sender control
// turns session events into chunk send orders, end packets and final status
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one event per transaction: tuser is the event code, tdata
//   the session id of a start packet and the cumulative ack of an ack packet.
//   m_axis carries the results: tuser is the result kind, tdata the chunk
//   number (chunk total for an end packet, zero for a status), tlast marks
//   the final result of an event. an event may cause no result at all.
//   the cfg channel writes the five registers by index and is always ready;
//   the user must write it only while no event is in flight (not enforced).
// timing
//   one event at a time: the event is taken and decoded, then the sequencer
//   steps through the resend loop, the window update and the fill loop or
//   the status result as the event needs; a new event is taken only once
//   the last result of the event is issued. the result rate is set by the
//   single output register, one per cycle while m_axis is ready.
// reset and stall
//   reset returns to the idle phase, window pointers at zero, and loads the
//   register defaults (window 8, end tries 5). a stalled m_axis holds the
//   current result in the output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module go_back_n_sender (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // packet_session [31:0], ack_number [63:32]
  input  logic [1:0]  s_axis_tuser,  // func [1:0]

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // chunk_number [31:0]
  output logic [2:0]  m_axis_tuser,  // kind [2:0]
  output logic        m_axis_tlast,  // last

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import gbn_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file with the window already clamped
  gbn_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: decode, resend loop, window fill, status results
  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // window state, compares and the output register
  gbn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
